// ===== design/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and helpers for the three-wire clock-chip master.
// Holds the request and mode codes, the queue geometry, the item structs
// passed between the front and back parts, and the BCD conversion helpers.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam int unsigned WR_BITS_W = 44;
  localparam int unsigned SHIFT_W   = 52;

  localparam logic [5:0] READ_BITS  = 6'd52;
  localparam logic [5:0] WRITE_BITS = 6'd44;

  // Request codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  // One classified item waiting for the sequencer.
  typedef struct packed {
    req_kind_t             kind;
    logic [WR_BITS_W-1:0]  wr_bits;
    logic                  data_in;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic       chip_enable;
    logic       io_mode;
    logic       serial_clock;
    logic       data_out;
    logic       done_res;
    logic [7:0] got_year;
    logic [7:0] got_month;
    logic [7:0] got_day;
    logic [3:0] got_weekday;
    logic [7:0] got_hour;
    logic [7:0] got_minute;
    logic [7:0] got_second;
  } res_t;

  // Binary to BCD byte for a 7-bit value. The quotient by ten comes from a
  // multiply by 205/2048, which is exact over the whole 7-bit range.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = {8'd0, v} * 15'd205;
    q    = prod[14:11];
    r    = v - 7'({q, 3'b000} + {2'b00, q, 1'b0});
    return {q, r[3:0]};
  endfunction

  // Units digit of a 4-bit value, the only nibble the weekday keeps.
  function automatic logic [3:0] nibble_units(input logic [3:0] v);
    return (v >= 4'd10) ? 4'(v - 4'd10) : v;
  endfunction

  // Tens times ten plus units, with no check on the digits.
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

endpackage

// ===== design/rtt_front.sv =====
// ----------------------------------------------------------------------------
// rtt_front: input side of the clock-chip master.
// Accepts items, classifies the request code, packs the BCD write word and
// holds classified items in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module rtt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_req_type,
  input  logic [6:0]        in_set_year,
  input  logic [6:0]        in_set_month,
  input  logic [6:0]        in_set_day,
  input  logic [3:0]        in_set_weekday,
  input  logic [6:0]        in_set_hour,
  input  logic [6:0]        in_set_minute,
  input  logic              in_data_in,
  output rtt_pkg::cmd_t     cmd,
  output logic              cmd_valid,
  input  logic              cmd_pop
);

  rtt_pkg::cmd_t                 q_mem_r [rtt_pkg::QDEPTH];
  logic [rtt_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rtt_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rtt_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          push_ok;
  logic                          pop_ok;
  rtt_pkg::cmd_t                 new_cmd;

  // Classification: code three is treated as a plain tick.
  always_comb begin
    new_cmd.data_in = in_data_in;
    new_cmd.wr_bits = {rtt_pkg::to_bcd(in_set_minute),
                       rtt_pkg::to_bcd(in_set_hour),
                       rtt_pkg::nibble_units(in_set_weekday),
                       rtt_pkg::to_bcd(in_set_day),
                       rtt_pkg::to_bcd(in_set_month),
                       rtt_pkg::to_bcd(in_set_year)};
    unique case (in_req_type)
      rtt_pkg::REQ_READ:  new_cmd.kind = rtt_pkg::REQ_READ;
      rtt_pkg::REQ_WRITE: new_cmd.kind = rtt_pkg::REQ_WRITE;
      default:            new_cmd.kind = rtt_pkg::REQ_TICK;
    endcase
  end

  assign in_full   = (cnt_r == rtt_pkg::QCNT_W'(rtt_pkg::QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == rtt_pkg::QPTR_W'(rtt_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == rtt_pkg::QPTR_W'(rtt_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== design/rtt_back.sv =====
// ----------------------------------------------------------------------------
// rtt_back: transfer sequencer of the clock-chip master.
// Steps the serial transfer once per classified item, drives the pin levels,
// decodes read data on the finishing tick and queues one result per item.
// ----------------------------------------------------------------------------
module rtt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rtt_pkg::cmd_t     cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output rtt_pkg::res_t     res
);

  rtt_pkg::mode_t                 mode_r, mode_nxt;
  logic [5:0]                     cnt_r, cnt_nxt;
  logic                           phase_r, phase_nxt;
  logic [rtt_pkg::SHIFT_W-1:0]    shift_r, shift_nxt;
  logic                           ce_r, ce_nxt;
  logic                           io_r, io_nxt;
  logic                           dat_r, dat_nxt;
  logic                           sclk_r, sclk_nxt;

  rtt_pkg::res_t                  rq_mem_r [rtt_pkg::QDEPTH];
  logic [rtt_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rtt_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rtt_pkg::QCNT_W-1:0]     rcnt_r, rcnt_nxt;

  logic                           step;
  logic                           rd_ok;
  logic                           res_space;
  logic                           finish;
  logic                           done;
  logic                           got;
  rtt_pkg::res_t                  new_res;

  assign out_empty = (rcnt_r == '0);
  assign rd_ok     = out_pop && !out_empty;
  assign res_space = (rcnt_r != rtt_pkg::QCNT_W'(rtt_pkg::QDEPTH)) || rd_ok;
  assign step      = cmd_valid && res_space;
  assign cmd_pop   = step;
  assign res       = rq_mem_r[rd_ptr_r];

  always_comb begin
    unique case (mode_r)
      rtt_pkg::MODE_READ:  finish = (cnt_r >= rtt_pkg::READ_BITS);
      rtt_pkg::MODE_WRITE: finish = (cnt_r >= rtt_pkg::WRITE_BITS);
      default:             finish = 1'b0;
    endcase
  end

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (step) begin
      unique case (mode_r)
        rtt_pkg::MODE_IDLE: begin
          if (cmd.kind == rtt_pkg::REQ_READ) begin
            mode_nxt = rtt_pkg::MODE_READ;
          end else if (cmd.kind == rtt_pkg::REQ_WRITE) begin
            mode_nxt = rtt_pkg::MODE_WRITE;
          end
        end
        rtt_pkg::MODE_READ, rtt_pkg::MODE_WRITE: begin
          if (finish) begin
            mode_nxt = rtt_pkg::MODE_IDLE;
          end
        end
        default: mode_nxt = rtt_pkg::MODE_IDLE;
      endcase
    end
  end

  // Datapath and pin levels for this tick.
  always_comb begin
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    ce_nxt    = ce_r;
    io_nxt    = io_r;
    dat_nxt   = dat_r;
    sclk_nxt  = sclk_r;
    done      = 1'b0;
    got       = 1'b0;
    if (step) begin
      unique case (mode_r)
        rtt_pkg::MODE_IDLE: begin
          if (cmd.kind == rtt_pkg::REQ_READ) begin
            cnt_nxt   = '0;
            phase_nxt = 1'b0;
            shift_nxt = '0;
            ce_nxt    = 1'b1;
            io_nxt    = 1'b0;
            dat_nxt   = 1'b0;
            sclk_nxt  = 1'b0;
          end else if (cmd.kind == rtt_pkg::REQ_WRITE) begin
            cnt_nxt   = '0;
            phase_nxt = 1'b0;
            shift_nxt = {{(rtt_pkg::SHIFT_W - rtt_pkg::WR_BITS_W){1'b0}}, cmd.wr_bits};
            ce_nxt    = 1'b1;
            io_nxt    = 1'b1;
            sclk_nxt  = 1'b0;
          end
        end
        rtt_pkg::MODE_READ: begin
          if (finish) begin
            ce_nxt    = 1'b0;
            sclk_nxt  = 1'b0;
            done      = 1'b1;
            got       = 1'b1;
            cnt_nxt   = '0;
            phase_nxt = 1'b0;
          end else if (!phase_r) begin
            sclk_nxt = 1'b1;
            if (cmd.data_in) begin
              shift_nxt[cnt_r] = 1'b1;
            end
            phase_nxt = 1'b1;
          end else begin
            sclk_nxt  = 1'b0;
            cnt_nxt   = cnt_r + 6'd1;
            phase_nxt = 1'b0;
          end
        end
        rtt_pkg::MODE_WRITE: begin
          if (finish) begin
            ce_nxt    = 1'b0;
            sclk_nxt  = 1'b0;
            done      = 1'b1;
            cnt_nxt   = '0;
            phase_nxt = 1'b0;
          end else if (!phase_r) begin
            sclk_nxt  = 1'b0;
            dat_nxt   = shift_r[cnt_r];
            phase_nxt = 1'b1;
          end else begin
            sclk_nxt  = 1'b1;
            cnt_nxt   = cnt_r + 6'd1;
            phase_nxt = 1'b0;
          end
        end
        default: begin
          cnt_nxt   = '0;
          phase_nxt = 1'b0;
        end
      endcase
    end
  end

  // Result item for this tick; decoded fields are zero unless a read ends.
  always_comb begin
    new_res              = '0;
    new_res.chip_enable  = ce_nxt;
    new_res.io_mode      = io_nxt;
    new_res.serial_clock = sclk_nxt;
    new_res.data_out     = dat_nxt;
    new_res.done_res     = done;
    if (got) begin
      new_res.got_year    = rtt_pkg::from_bcd(shift_r[7:0]);
      new_res.got_month   = rtt_pkg::from_bcd(shift_r[15:8]);
      new_res.got_day     = rtt_pkg::from_bcd(shift_r[23:16]);
      new_res.got_weekday = shift_r[27:24];
      new_res.got_hour    = rtt_pkg::from_bcd(shift_r[35:28]);
      new_res.got_minute  = rtt_pkg::from_bcd(shift_r[43:36]);
      new_res.got_second  = rtt_pkg::from_bcd(shift_r[51:44]);
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    rcnt_nxt   = rcnt_r;
    if (step) begin
      wr_ptr_nxt = (wr_ptr_r == rtt_pkg::QPTR_W'(rtt_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == rtt_pkg::QPTR_W'(rtt_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (step && !rd_ok) begin
      rcnt_nxt = rcnt_r + 1'b1;
    end else if (rd_ok && !step) begin
      rcnt_nxt = rcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rtt_pkg::MODE_IDLE;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
      ce_r     <= 1'b0;
      io_r     <= 1'b0;
      dat_r    <= 1'b0;
      sclk_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      rcnt_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      ce_r     <= ce_nxt;
      io_r     <= io_nxt;
      dat_r    <= dat_nxt;
      sclk_r   <= sclk_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      rcnt_r   <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (step) begin
      rq_mem_r[wr_ptr_r] <= new_res;
    end
  end

endmodule

// ===== design/three_wire_rtc_time_transfer.sv =====
// ----------------------------------------------------------------------------
// three_wire_rtc_time_transfer: serial master for a three-wire clock chip.
// Each input item is one tick; each tick yields one result item with the
// pin levels and, at the end of a read, the decoded time fields.
// ----------------------------------------------------------------------------
// Usage:
// The input channel is a queue: an item is taken at a clock edge where
// in_push is high and in_full is low. Each item carries a request code
// (tick, start read, start write), the binary time fields for a write and
// the level sampled on the chip's data pin. The result channel is a queue
// as well: while out_empty is low the oldest result item is on the out_
// ports, and out_pop takes it.
// Every accepted item gives exactly one result item. The result of an item
// is visible once it has passed both queues: the item waits in the
// classification queue until the sequencer takes it, and the sequencer then
// writes its result into the result queue. One item per cycle is sustained
// while the result queue has room; that figure is set by the sequencer, which
// advances the transfer by one tick for each item it takes.
// A write takes 1 + 88 + 1 ticks, a read 1 + 104 + 1 ticks.
// When the receiver stalls, the result queue fills, the sequencer holds and
// the input queue fills behind it; nothing is dropped. Synchronous reset
// empties both queues, returns the sequencer to idle and sets its pin levels low.
// ----------------------------------------------------------------------------
module three_wire_rtc_time_transfer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_req_type,
  input  logic [6:0] in_set_year,
  input  logic [6:0] in_set_month,
  input  logic [6:0] in_set_day,
  input  logic [3:0] in_set_weekday,
  input  logic [6:0] in_set_hour,
  input  logic [6:0] in_set_minute,
  input  logic       in_data_in,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_chip_enable,
  output logic       out_io_mode,
  output logic       out_serial_clock,
  output logic       out_data_out,
  output logic       out_done_res,
  output logic [7:0] out_got_year,
  output logic [7:0] out_got_month,
  output logic [7:0] out_got_day,
  output logic [3:0] out_got_weekday,
  output logic [7:0] out_got_hour,
  output logic [7:0] out_got_minute,
  output logic [7:0] out_got_second
);

  rtt_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  rtt_pkg::res_t res;

  // The front classifies requests and packs the BCD write word, so the
  // sequencer only ever sees ready-made commands.
  rtt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_set_year    (in_set_year),
    .in_set_month   (in_set_month),
    .in_set_day     (in_set_day),
    .in_set_weekday (in_set_weekday),
    .in_set_hour    (in_set_hour),
    .in_set_minute  (in_set_minute),
    .in_data_in     (in_data_in),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop)
  );

  // The back runs the transfer and owns the result queue.
  rtt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_chip_enable  = res.chip_enable;
  assign out_io_mode      = res.io_mode;
  assign out_serial_clock = res.serial_clock;
  assign out_data_out     = res.data_out;
  assign out_done_res     = res.done_res;
  assign out_got_year     = res.got_year;
  assign out_got_month    = res.got_month;
  assign out_got_day      = res.got_day;
  assign out_got_weekday  = res.got_weekday;
  assign out_got_hour     = res.got_hour;
  assign out_got_minute   = res.got_minute;
  assign out_got_second   = res.got_second;

endmodule

// ===== design/rtt_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_checker: port-level checks for the clock-chip master.
// Watches the top level's channels and pin results and is bound to it.
// ----------------------------------------------------------------------------
module rtt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic       out_chip_enable,
  input logic       out_serial_clock,
  input logic       out_done_res,
  input logic [7:0] out_got_year,
  input logic [7:0] out_got_month,
  input logic [7:0] out_got_day,
  input logic [3:0] out_got_weekday,
  input logic [7:0] out_got_hour,
  input logic [7:0] out_got_minute,
  input logic [7:0] out_got_second
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // The finishing tick drops chip enable and the clock.
  a_done_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_done_res) |-> (!out_chip_enable && !out_serial_clock))
    else $error("pins active on finishing tick");

  // Decoded fields stay zero on every tick that does not finish a transfer.
  a_got_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_done_res) |->
      (out_got_year == 8'd0 && out_got_month == 8'd0 && out_got_day == 8'd0 &&
       out_got_weekday == 4'd0 && out_got_hour == 8'd0 &&
       out_got_minute == 8'd0 && out_got_second == 8'd0))
    else $error("decoded fields nonzero outside finishing tick");

  // A waiting result is held until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_chip_enable) && $stable(out_done_res)))
    else $error("stalled result changed");

endmodule

bind three_wire_rtc_time_transfer rtt_checker u_rtt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_chip_enable  (out_chip_enable),
  .out_serial_clock (out_serial_clock),
  .out_done_res     (out_done_res),
  .out_got_year     (out_got_year),
  .out_got_month    (out_got_month),
  .out_got_day      (out_got_day),
  .out_got_weekday  (out_got_weekday),
  .out_got_hour     (out_got_hour),
  .out_got_minute   (out_got_minute),
  .out_got_second   (out_got_second)
);
